// ===== src/bbr_pkg.sv =====
// Shared types, constants and helpers of the 3x3 box blur unit.
`timescale 1ns / 1ps

package bbr_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int CHAN_W        = 8;
    localparam int PIX_W         = 3 * CHAN_W;
    localparam int COL_SUM_W     = 10;
    localparam int WIN_SUM_W     = 12;
    localparam int ROW_W         = 13;
    localparam int WIDTH_REG_W   = 11;
    localparam int HEIGHT_REG_W  = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 1;
    localparam int MIDQ_DEPTH    = 4;
    localparam int OUTQ_DEPTH    = 4;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // floor(s / 9) for s <= 2295 as (s * 7282) >> 16
    localparam logic [12:0] DIV9_RECIP = 13'd7282;
    localparam int          DIV9_SHIFT = 16;

    typedef enum logic {
        KIND_PIXEL,
        KIND_FLUSH
    } t_kind;

    // where the result pixel comes from
    typedef enum logic [1:0] {
        SEL_CENTER,
        SEL_CORNER,
        SEL_BLUR,
        SEL_STORE
    } t_sel;

    typedef struct packed {
        t_kind             kind;
        t_sel              sel;
        logic              emit;
        logic              last_col;
        logic              frame_end;
        logic [PIX_W-1:0]  pixel;
    } t_op;

    typedef struct packed {
        logic              frame_end;
        logic [PIX_W-1:0]  pixel;
    } t_result;

    typedef struct packed {
        logic                                blur;
        logic                                frame_end;
        logic [PIX_W-1:0]                    pixel;
        logic [2:0][WIN_SUM_W-1:0]           sum;
    } t_stage2;

    function automatic logic [CHAN_W-1:0] div9(input logic [WIN_SUM_W-1:0] s);
        logic [24:0] prod;
        prod = 25'(s) * 25'(DIV9_RECIP);
        return prod[DIV9_SHIFT +: CHAN_W];
    endfunction

endpackage

// ===== src/box_blur_3x3_rgb_unit.sv =====
// Top level of the streaming 3x3 box blur on 24-bit BGR pixels.
`timescale 1ns / 1ps

// Usage
//   Input queue: drive i_command and the pixel channels, raise push; a request
//   is taken on a rising edge with push high and full low. A pixel request
//   carries the next pixel of the image in raster order; a flush request
//   drains one pixel still pending once the whole image is in.
//   Result queue: while empty is low the oldest result is on the o_ ports;
//   it is taken on a rising edge with pop high. o_frame_end marks the final
//   pixel of an image.
//   Configuration: i_cfg_valid with i_cfg_index/i_cfg_data writes image width
//   (index 0) or height (index 1); o_cfg_ready is always high. Write only
//   while the block is idle; every write restarts the image.
// Timing
//   One request per clock while full is low. Results lag the pixel stream by
//   width+1 pixels. The rate is set by the two row stores, each read and
//   written once per pixel through one port, with forwarding across
//   back-to-back columns.
// Reset and stalls
//   Reset empties both queues and restores width 640, height 480. Row stores
//   need no clearing. If pop is held low, results queue up, the back end
//   holds operations, the operation queue fills and full rises.
module box_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_command,
    input  logic [7:0]                        i_in_blue,
    input  logic [7:0]                        i_in_green,
    input  logic [7:0]                        i_in_red,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        o_out_blue,
    output logic [7:0]                        o_out_green,
    output logic [7:0]                        o_out_red,
    output logic                              o_frame_end,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bbr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [bbr_pkg::WIDTH_REG_W-1:0]  r_width;
    logic [bbr_pkg::HEIGHT_REG_W-1:0] r_height;
    logic                             cfg_wr;
    logic [CW-1:0]                    w_last;
    logic [bbr_pkg::ROW_W-1:0]        h_last;

    logic                             accept;
    logic                             op_push, op_pop, midq_empty;
    bbr_pkg::t_op                     op_in, op_out;
    logic [CW-1:0]                    addr_in, addr_out;
    bbr_pkg::t_result                 result;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // hold the configuration registers; a write truncates to the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bbr_pkg::WIDTH_RESET;
            r_height <= bbr_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                bbr_pkg::CFG_IDX_WIDTH:  r_width  <= i_cfg_data[bbr_pkg::WIDTH_REG_W-1:0];
                bbr_pkg::CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp width to 1..MAX_WIDTH and height to at least 1, as last indexes
    always_comb begin
        if (r_width == '0) begin
            w_last = '0;
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_width - bbr_pkg::WIDTH_REG_W'(1));
        end
        h_last = (r_height == '0) ? '0 : r_height - bbr_pkg::HEIGHT_REG_W'(1);
    end

    assign accept = push && !full;

    bbr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_w_last  (w_last),
        .i_h_last  (h_last),
        .i_accept  (accept),
        .i_command (i_command),
        .i_pixel   ({i_in_red, i_in_green, i_in_blue}),
        .o_push    (op_push),
        .o_op      (op_in),
        .o_addr    (addr_in)
    );

    // decouple classification from the store pipeline
    bbr_fifo #(
        .W     ($bits(bbr_pkg::t_op) + CW),
        .DEPTH (bbr_pkg::MIDQ_DEPTH)
    ) u_midq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  ({addr_in, op_in}),
        .o_full  (full),
        .i_pop   (op_pop),
        .o_data  ({addr_out, op_out}),
        .o_empty (midq_empty),
        .o_count ()
    );

    bbr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!midq_empty),
        .i_op       (op_out),
        .i_addr     (addr_out),
        .o_op_pop   (op_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (result)
    );

    assign o_out_blue  = result.pixel[7:0];
    assign o_out_green = result.pixel[15:8];
    assign o_out_red   = result.pixel[23:16];
    assign o_frame_end = result.frame_end;

endmodule

// ===== src/bbr_fifo.sv =====
// Small first-in first-out queue of packed words.
`timescale 1ns / 1ps

module bbr_fifo #(
    parameter int W     = bbr_pkg::PIX_W,
    parameter int DEPTH = bbr_pkg::MIDQ_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [W-1:0]                  i_data,
    output logic                          o_full,
    input  logic                          i_pop,
    output logic [W-1:0]                  o_data,
    output logic                          o_empty,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0] r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/bbr_front.sv =====
// Front end: tracks raster position and turns each request into a back-end operation.
`timescale 1ns / 1ps

module bbr_front #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_restart,
    input  logic [$clog2(MAX_WIDTH)-1:0]       i_w_last,
    input  logic [bbr_pkg::ROW_W-1:0]          i_h_last,
    input  logic                               i_accept,
    input  logic                               i_command,
    input  logic [bbr_pkg::PIX_W-1:0]          i_pixel,
    output logic                               o_push,
    output bbr_pkg::t_op                       o_op,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = bbr_pkg::ROW_W;

    // input position, rows-complete flag, output position, image-drained flag
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_rows_done, n_rows_done;
    logic [CW-1:0] r_ox, n_ox;
    logic [RW-1:0] r_oy, n_oy;
    logic          r_done, n_done;

    logic [CW-1:0] c_b, ox_b;
    logic [RW-1:0] r_b, oy_b;
    logic          last_col, emit, row_ge2;

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_rows_done = r_rows_done;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_done      = r_done;
        o_push      = 1'b0;
        o_op        = '0;
        o_addr      = '0;
        c_b         = r_col;
        r_b         = r_row;
        ox_b        = r_ox;
        oy_b        = r_oy;
        last_col    = 1'b0;
        emit        = 1'b0;
        row_ge2     = 1'b0;
        if (i_restart) begin
            n_col       = '0;
            n_row       = '0;
            n_rows_done = 1'b0;
            n_ox        = '0;
            n_oy        = '0;
            n_done      = 1'b0;
        end else if (i_accept) begin
            if (i_command == bbr_pkg::CMD_PIXEL) begin
                // a pixel after a complete image opens the next one
                if (r_rows_done) begin
                    c_b         = '0;
                    r_b         = '0;
                    ox_b        = '0;
                    oy_b        = '0;
                    n_rows_done = 1'b0;
                    n_done      = 1'b0;
                end
                row_ge2  = (r_b[RW-1:1] != '0);
                last_col = (c_b == i_w_last);
                emit     = row_ge2 || ((r_b == RW'(1)) && (c_b != '0));
                o_push        = 1'b1;
                o_addr        = c_b;
                o_op.kind     = bbr_pkg::KIND_PIXEL;
                o_op.emit     = emit;
                o_op.last_col = last_col;
                o_op.pixel    = i_pixel;
                if (c_b == '0) begin
                    o_op.sel = bbr_pkg::SEL_CORNER;
                end else if (row_ge2 && (c_b[CW-1:1] != '0)) begin
                    o_op.sel = bbr_pkg::SEL_BLUR;
                end else begin
                    o_op.sel = bbr_pkg::SEL_CENTER;
                end
                n_col = last_col ? '0 : c_b + CW'(1);
                n_row = r_b;
                if (last_col) begin
                    if (r_b == i_h_last) begin
                        n_rows_done = 1'b1;
                    end else begin
                        n_row = r_b + RW'(1);
                    end
                end
                n_ox = ox_b;
                n_oy = oy_b;
                if (emit) begin
                    n_ox = (ox_b == i_w_last) ? '0 : ox_b + CW'(1);
                    n_oy = (ox_b == i_w_last) ? oy_b + RW'(1) : oy_b;
                end
            end else if (r_rows_done && !r_done) begin
                // drain one pending pixel once the image is in; any other flush is dropped
                o_push         = 1'b1;
                o_addr         = r_ox;
                o_op.kind      = bbr_pkg::KIND_FLUSH;
                o_op.emit      = 1'b1;
                o_op.sel       = (r_oy == i_h_last) ? bbr_pkg::SEL_STORE : bbr_pkg::SEL_CORNER;
                o_op.frame_end = (r_oy == i_h_last) && (r_ox == i_w_last);
                n_done         = o_op.frame_end;
                n_ox = (r_ox == i_w_last) ? '0 : r_ox + CW'(1);
                n_oy = (r_ox == i_w_last) ? r_oy + RW'(1) : r_oy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_rows_done <= 1'b0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_done      <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_rows_done <= n_rows_done;
            r_ox        <= n_ox;
            r_oy        <= n_oy;
            r_done      <= n_done;
        end
    end

endmodule

// ===== src/bbr_back.sv =====
// Back end: line stores, 3x3 window, blur arithmetic and the result queue.
`timescale 1ns / 1ps

module bbr_back #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_op_valid,
    input  bbr_pkg::t_op                  i_op,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_addr,
    output logic                          o_op_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output bbr_pkg::t_result              o_result
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int PW    = bbr_pkg::PIX_W;
    localparam int CH    = bbr_pkg::CHAN_W;
    localparam int QD    = bbr_pkg::OUTQ_DEPTH;
    localparam int QCW   = $clog2(QD + 1);
    localparam int OCW   = $clog2(QD + 3);

    // line stores
    logic [PW-1:0] r_upper_mem  [MAX_WIDTH];
    logic [PW-1:0] r_middle_mem [MAX_WIDTH];
    logic [PW-1:0] r_rd_up, r_rd_mid;

    // stage 1
    logic          r_s1_valid;
    bbr_pkg::t_op  r_s1_op;
    logic [CW-1:0] r_s1_addr;

    // latest store write, forwarded to the next read of the same column
    logic          r_fw_valid;
    logic [CW-1:0] r_fw_addr;
    logic [PW-1:0] r_fw_up, r_fw_mid;

    // window: sums of the two older columns, centre-to-be, last-column pixel
    logic [2:0][bbr_pkg::COL_SUM_W-1:0] r_cs_c1, r_cs_c2;
    logic [PW-1:0]                      r_win5;
    logic [PW-1:0]                      r_corner;

    // stage 2
    logic             r_s2_valid;
    bbr_pkg::t_stage2 r_s2, n_s2;

    logic [PW-1:0]                      up_eff, mid_eff;
    logic [2:0][bbr_pkg::COL_SUM_W-1:0] col_sum;
    logic                               pix_wr;
    logic [QCW-1:0]                     outq_count;
    logic [OCW-1:0]                     occ;
    logic                               outq_full;
    bbr_pkg::t_result                   res;

    assign pix_wr = r_s1_valid && (r_s1_op.kind == bbr_pkg::KIND_PIXEL);

    // results in flight plus queued must leave room, so the pipe never stalls
    assign occ      = OCW'(outq_count) + OCW'(r_s1_valid && r_s1_op.emit) + OCW'(r_s2_valid);
    assign o_op_pop = i_op_valid && !outq_full && (occ < OCW'(QD));

    always_comb begin
        up_eff  = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_up  : r_rd_up;
        mid_eff = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_mid : r_rd_mid;
        n_s2    = '0;
        for (int ch = 0; ch < 3; ch++) begin
            col_sum[ch] = bbr_pkg::COL_SUM_W'(up_eff[CH*ch +: CH])
                        + bbr_pkg::COL_SUM_W'(mid_eff[CH*ch +: CH])
                        + bbr_pkg::COL_SUM_W'(r_s1_op.pixel[CH*ch +: CH]);
            n_s2.sum[ch] = bbr_pkg::WIN_SUM_W'(r_cs_c1[ch])
                         + bbr_pkg::WIN_SUM_W'(r_cs_c2[ch])
                         + bbr_pkg::WIN_SUM_W'(col_sum[ch]);
        end
        n_s2.frame_end = r_s1_op.frame_end;
        case (r_s1_op.sel)
            bbr_pkg::SEL_CORNER: n_s2.pixel = r_corner;
            bbr_pkg::SEL_STORE:  n_s2.pixel = mid_eff;
            bbr_pkg::SEL_BLUR: begin
                n_s2.pixel = r_win5;
                n_s2.blur  = 1'b1;
            end
            default:             n_s2.pixel = r_win5;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_up  <= r_upper_mem[i_addr];
        r_rd_mid <= r_middle_mem[i_addr];
        if (pix_wr) begin
            r_upper_mem[r_s1_addr]  <= mid_eff;
            r_middle_mem[r_s1_addr] <= r_s1_op.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_s1_op   <= i_op;
            r_s1_addr <= i_addr;
        end
        if (pix_wr) begin
            r_fw_addr <= r_s1_addr;
            r_fw_up   <= mid_eff;
            r_fw_mid  <= r_s1_op.pixel;
            r_cs_c1   <= r_cs_c2;
            r_cs_c2   <= col_sum;
            r_win5    <= mid_eff;
            if (r_s1_op.last_col) begin
                r_corner <= mid_eff;
            end
        end
        r_s2 <= n_s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_op_pop;
            r_s2_valid <= r_s1_valid && r_s1_op.emit;
            if (pix_wr) begin
                r_fw_valid <= 1'b1;
            end
        end
    end

    always_comb begin
        res.frame_end = r_s2.frame_end;
        if (r_s2.blur) begin
            res.pixel = {bbr_pkg::div9(r_s2.sum[2]),
                         bbr_pkg::div9(r_s2.sum[1]),
                         bbr_pkg::div9(r_s2.sum[0])};
        end else begin
            res.pixel = r_s2.pixel;
        end
    end

    bbr_fifo #(
        .W     ($bits(bbr_pkg::t_result)),
        .DEPTH (QD)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (res),
        .o_full  (outq_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty),
        .o_count (outq_count)
    );

endmodule

// ===== src/bbr_checker.sv =====
// Port-level checks of the box blur unit and their binding to the top level.
`timescale 1ns / 1ps

module bbr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_blue,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_red,
    input logic       o_frame_end
);

    // reset drops every queued result
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // reset leaves room for a request
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input reports full after reset");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_blue) && $stable(o_out_green)
                              && $stable(o_out_red) && $stable(o_frame_end)))
        else $error("waiting result changed or vanished");

endmodule

bind box_blur_3x3_rgb_unit bbr_checker u_bbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_out_blue  (o_out_blue),
    .o_out_green (o_out_green),
    .o_out_red   (o_out_red),
    .o_frame_end (o_frame_end)
);
